@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a plain condition on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

@@ rtl/core/hbdd_pkg.sv @@
// Types and constants of the HTTP/BMP deframer and descrambler.
`default_nettype none

package hbdd_pkg;

  localparam int unsigned IMAGE_HEADER_BYTES = 54;
  localparam int unsigned LEN_FIRST_BYTE     = 34;
  localparam int unsigned HDR_POS_W          = 6;

  localparam logic [31:0] KEY_RESET = 32'h70BC3F4A;
  localparam logic [7:0]  CHAR_CR   = 8'h0D;
  localparam logic [7:0]  CHAR_LF   = 8'h0A;

  localparam logic [7:0] DELIM_PAT [4] = '{CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF};

  localparam logic [HDR_POS_W-1:0] HDR_LAST  = HDR_POS_W'(IMAGE_HEADER_BYTES - 1);
  localparam logic [HDR_POS_W-1:0] LEN_FIRST = HDR_POS_W'(LEN_FIRST_BYTE);
  localparam logic [HDR_POS_W-1:0] LEN_END   = HDR_POS_W'(LEN_FIRST_BYTE + 4);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       frame_end;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/http_bmp_deframer_descrambler.sv @@
// Top level of the HTTP/BMP deframer and descrambler.
`default_nettype none

// Takes one received byte per cycle, hunts for CR LF CR LF, skips the 54-byte
// image header while capturing the little-endian payload length from header
// bytes 34 to 37, then emits that many payload bytes, each inverted and XORed
// with the next byte of scramble_key (rotating index kept across frames); the
// last payload byte carries tlast. Delimiter and header bytes give no output.
// Every byte is processed in the cycle it is accepted and its result lands in
// a single output register, so the block sustains one byte per cycle; s_tready
// drops only while that output register holds a result that m_tready refuses.
// A key write takes effect from the next payload byte; cfg_ready is always high.
module http_bmp_deframer_descrambler (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,    // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,    // [7:0] payload_byte
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);
  import hbdd_pkg::*;

  logic        in_ready;
  logic        in_fire;
  logic [31:0] scramble_key;
  logic        res_valid;
  res_t        res;

  assign s_tready  = in_ready;
  assign in_fire   = s_tvalid && in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scramble_key <= KEY_RESET;
    end else if (cfg_valid) begin
      scramble_key <= cfg_data;
    end
  end

  hbdd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .in_fire      (in_fire),
    .rx_byte      (s_tdata),
    .scramble_key (scramble_key),
    .res_valid    (res_valid),
    .res          (res)
  );

  hbdd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .in_ready  (in_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

@@ rtl/core/hbdd_parser.sv @@
// Delimiter hunt, header skip, length capture and payload descrambling.
`default_nettype none
`include "assert_macros.svh"

module hbdd_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_fire,
  input  wire logic [7:0]    rx_byte,
  input  wire logic [31:0]   scramble_key,
  output logic               res_valid,
  output hbdd_pkg::res_t     res
);
  import hbdd_pkg::*;

  phase_t                 phase, phase_next;
  logic [2:0]             matched, matched_next;
  logic [HDR_POS_W-1:0]   hdr_pos, hdr_pos_next;
  logic [31:0]            len_col, len_col_next;
  logic [31:0]            remaining, remaining_next;
  logic [1:0]             key_pos, key_pos_next;

  logic [2:0]             match_cnt;
  logic                   delim_done;
  logic                   hdr_last;
  logic                   in_len_field;
  logic [HDR_POS_W-1:0]   len_off;
  logic [31:0]            len_upd;
  logic                   pay_active;
  logic [31:0]            rem_dec;
  logic [7:0]             key_byte;
  phase_t                 hunt_phase;

  // Restart the partial match on a CR that breaks it.
  assign match_cnt = (rx_byte == DELIM_PAT[matched[1:0]]) ? matched + 3'd1 :
                     (rx_byte == CHAR_CR)                 ? 3'd1 : 3'd0;
  assign delim_done = (match_cnt == 3'd4);
  assign hunt_phase = delim_done ? PH_HEADER : PH_HUNT;

  assign hdr_last     = (hdr_pos == HDR_LAST);
  assign in_len_field = (hdr_pos >= LEN_FIRST) && (hdr_pos < LEN_END);
  assign len_off      = hdr_pos - LEN_FIRST;

  always_comb begin
    len_upd = len_col;
    if (in_len_field) begin
      case (len_off[1:0])
        2'd0:    len_upd[7:0]   = rx_byte;
        2'd1:    len_upd[15:8]  = rx_byte;
        2'd2:    len_upd[23:16] = rx_byte;
        default: len_upd[31:24] = rx_byte;
      endcase
    end
  end

  assign pay_active = (phase == PH_PAYLOAD) && (remaining != 32'd0);
  assign rem_dec    = remaining - 32'd1;
  assign key_byte   = scramble_key[{key_pos, 3'b000} +: 8];

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (in_fire) begin
      unique case (phase)
        PH_HEADER: begin
          if (hdr_last) begin
            phase_next = (len_upd == 32'd0) ? PH_HUNT : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (pay_active) begin
            phase_next = (rem_dec == 32'd0) ? PH_HUNT : PH_PAYLOAD;
          end else begin
            phase_next = hunt_phase;
          end
        end
        default: phase_next = hunt_phase;
      endcase
    end
  end

  // Datapath and result.
  always_comb begin
    matched_next   = matched;
    hdr_pos_next   = hdr_pos;
    len_col_next   = len_col;
    remaining_next = remaining;
    key_pos_next   = key_pos;
    res_valid      = 1'b0;
    res.payload_byte = ~rx_byte ^ key_byte;
    res.frame_end    = (rem_dec == 32'd0);
    if (in_fire) begin
      if (phase == PH_HEADER) begin
        len_col_next = len_upd;
        hdr_pos_next = hdr_last ? '0 : hdr_pos + HDR_POS_W'(1);
        if (hdr_last && (len_upd != 32'd0)) begin
          remaining_next = len_upd;
        end
      end else if (pay_active) begin
        res_valid      = 1'b1;
        key_pos_next   = key_pos + 2'd1;
        remaining_next = rem_dec;
        if (rem_dec == 32'd0) begin
          matched_next = 3'd0;
        end
      end else begin
        matched_next = delim_done ? 3'd0 : match_cnt;
        if (delim_done) begin
          hdr_pos_next = '0;
          len_col_next = 32'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HUNT;
      matched   <= 3'd0;
      hdr_pos   <= '0;
      len_col   <= 32'd0;
      remaining <= 32'd0;
      key_pos   <= 2'd0;
    end else begin
      phase     <= phase_next;
      matched   <= matched_next;
      hdr_pos   <= hdr_pos_next;
      len_col   <= len_col_next;
      remaining <= remaining_next;
      key_pos   <= key_pos_next;
    end
  end

  `ASSERT_ALWAYS(a_payload_nonempty, clk, rst, (phase != PH_PAYLOAD) || (remaining != 32'd0),
    "payload phase with nothing left to pass")
  `ASSERT_CLK(a_result_in_payload, clk, rst, res_valid |-> (phase == PH_PAYLOAD),
    "result outside payload phase")
  `ASSERT_CLK(a_last_ends_frame, clk, rst, (res_valid && res.frame_end) |=> (phase == PH_HUNT),
    "frame end did not return to hunting")
  `ASSERT_ALWAYS(a_hdr_pos_range, clk, rst, hdr_pos <= HDR_LAST,
    "header position past the image header")

endmodule

`default_nettype wire

@@ rtl/core/hbdd_out_reg.sv @@
// Result register that decouples the output stream from the input stream.
`default_nettype none
`include "assert_macros.svh"

module hbdd_out_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           res_valid,
  input  wire hbdd_pkg::res_t res,
  output logic                in_ready,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [7:0]          m_tdata,   // [7:0] payload_byte
  output logic                m_tlast
);
  import hbdd_pkg::*;

  logic hold_valid;
  res_t hold;

  // Take a new transaction whenever the held result leaves or none is held.
  assign in_ready = !hold_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      hold <= res;
    end
  end

  assign m_tvalid = hold_valid;
  assign m_tdata  = hold.payload_byte;
  assign m_tlast  = hold.frame_end;

  `ASSERT_CLK(a_stall_blocks_input, clk, rst, (hold_valid && !m_tready) |-> !in_ready,
    "input taken while result stalled")
  `ASSERT_CLK(a_result_lands, clk, rst, (res_valid && in_ready) |=> hold_valid,
    "result lost on its way to the output")

endmodule

`default_nettype wire

@@ bench/tb_http_bmp_deframer_descrambler.sv @@
// Self-checking testbench for the HTTP/BMP deframer and descrambler.
`default_nettype none

module tb_http_bmp_deframer_descrambler;
  timeunit 1ns;
  timeprecision 1ps;

  import hbdd_pkg::*;

  localparam int RX_HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES   = 4;
  localparam int MAX_REPORTS    = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;      // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;           // [7:0] payload_byte
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  // Byte stream waiting for the driver and descrambled bytes still due.
  logic [7:0] rx_pending[$];
  res_t       payload_expected[$];

  int sender_gap_pct = 0;
  int sink_gap_pct   = 0;
  logic rx_hold      = 1'b0;
  logic hold_request = 1'b0;

  int mismatches      = 0;
  int bytes_in        = 0;
  int results_checked = 0;
  int frames_sent     = 0;
  int key_writes      = 0;

  // Predicted block state.
  logic [31:0] key_setting = KEY_RESET;
  phase_t      dfr_phase   = PH_HUNT;
  logic [2:0]  delim_cnt   = '0;
  logic [5:0]  hdr_pos     = '0;
  logic [31:0] len_acc     = '0;
  logic [31:0] pay_left    = '0;
  logic [1:0]  key_idx     = '0;

  http_bmp_deframer_descrambler i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #2_400_000;
    $display("FAIL");
    $finish;
  end

  // Advance the deframer state by one accepted byte; queue a result if one is due.
  task automatic track_byte(input logic [7:0] b);
    logic [2:0] m;
    int unsigned p;
    res_t r;
    if (dfr_phase == PH_HEADER) begin
      p = hdr_pos;
      if (p >= LEN_FIRST_BYTE && p < LEN_FIRST_BYTE + 4)
        len_acc = len_acc | (32'(b) << (8 * (p - LEN_FIRST_BYTE)));
      p++;
      if (p >= IMAGE_HEADER_BYTES) begin
        hdr_pos = '0;
        if (len_acc == 0) begin
          dfr_phase = PH_HUNT;
        end else begin
          pay_left  = len_acc;
          dfr_phase = PH_PAYLOAD;
        end
      end else begin
        hdr_pos = 6'(p);
      end
    end else if (dfr_phase == PH_PAYLOAD && pay_left != 0) begin
      r.payload_byte = ~b ^ key_setting[8*key_idx +: 8];
      key_idx++;
      pay_left--;
      r.frame_end = (pay_left == 0);
      if (r.frame_end) begin
        dfr_phase = PH_HUNT;
        delim_cnt = '0;
      end
      payload_expected.push_back(r);
    end else begin
      dfr_phase = PH_HUNT;
      m = {1'b0, delim_cnt[1:0]};
      if (b == DELIM_PAT[m[1:0]])
        m = m + 3'd1;
      else if (b == CHAR_CR)
        m = 3'd1;
      else
        m = 3'd0;
      if (m == 3'd4) begin
        delim_cnt = '0;
        dfr_phase = PH_HEADER;
        hdr_pos   = '0;
        len_acc   = '0;
      end else begin
        delim_cnt = m;
      end
    end
  endtask

  // Stream driver.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        track_byte(s_tdata);
        bytes_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (rx_pending.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= rx_pending.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result sink: random back-pressure plus one long hold-off.
  always @(posedge clk) begin
    if (rst)
      m_tready <= 1'b0;
    else
      m_tready <= !rx_hold && ($urandom_range(99) >= sink_gap_pct);
  end

  initial begin
    wait (hold_request);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Result monitor.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.payload_byte = m_tdata;
      got.frame_end    = m_tlast;
      results_checked++;
      if (payload_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected transaction: byte %02h last %0b",
                   got.payload_byte, got.frame_end);
      end else begin
        want = payload_expected.pop_front();
        if (got.payload_byte !== want.payload_byte || got.frame_end !== want.frame_end) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch at result %0d: expected byte %02h last %0b, got byte %02h last %0b",
                     results_checked, want.payload_byte, want.frame_end,
                     got.payload_byte, got.frame_end);
        end
      end
    end
  end

  task automatic write_key(input logic [31:0] k);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid   <= 1'b0;
    key_setting = k;
    key_writes++;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (rx_pending.size() != 0 || s_tvalid || payload_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random filler that never carries CR or LF, so it cannot start a delimiter.
  task automatic push_noise(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(255));
      if (b == CHAR_CR || b == CHAR_LF)
        b = b ^ 8'h80;
      rx_pending.push_back(b);
    end
  endtask

  task automatic push_payload(input int n);
    logic [7:0] b;
    repeat (n) begin
      case ($urandom_range(7))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        2:       b = CHAR_CR;
        3:       b = CHAR_LF;
        default: b = 8'($urandom_range(255));
      endcase
      rx_pending.push_back(b);
    end
  endtask

  // Delimiter, image header carrying the length, then send_len payload bytes.
  task automatic push_frame(input logic [31:0] len, input int send_len);
    logic [7:0] b;
    for (int i = 0; i < 4; i++)
      rx_pending.push_back(DELIM_PAT[i]);
    for (int i = 0; i < IMAGE_HEADER_BYTES; i++) begin
      if (i >= LEN_FIRST_BYTE && i < LEN_FIRST_BYTE + 4)
        b = len[8*(i - LEN_FIRST_BYTE) +: 8];
      else
        b = 8'($urandom_range(255));
      rx_pending.push_back(b);
    end
    push_payload(send_len);
    frames_sent++;
  endtask

  // Mostly well-formed frames with random content, some noise and broken delimiters.
  task automatic run_random(input int min_bytes, input int min_results);
    int queued;
    int planned;
    int len;
    int cut;
    queued  = 0;
    planned = 0;
    while (queued < min_bytes || planned < min_results) begin
      case ($urandom_range(9))
        0: begin
          len = $urandom_range(1, 8);
          push_noise(len);
          queued += len;
        end
        1: begin
          cut = $urandom_range(1, 3);
          for (int i = 0; i < cut; i++)
            rx_pending.push_back(DELIM_PAT[i]);
          push_noise(1);
          queued += cut + 1;
        end
        2: begin
          push_frame(0, 0);
          queued += 4 + IMAGE_HEADER_BYTES;
        end
        default: begin
          len = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
          // an extra CR ahead of the delimiter forces a match restart
          if ($urandom_range(3) == 0) begin
            rx_pending.push_back(CHAR_CR);
            queued++;
          end
          push_frame(len, len);
          queued  += 4 + IMAGE_HEADER_BYTES + len;
          planned += len;
        end
      endcase
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    sender_gap_pct <= 28;
    sink_gap_pct   <= 72;

    // Directed: field extremes, delimiter restarts, zero length, split frame.
    rx_pending.push_back(8'h00);
    rx_pending.push_back(8'hFF);
    rx_pending.push_back(CHAR_CR);
    rx_pending.push_back(CHAR_LF);
    rx_pending.push_back(CHAR_CR);
    rx_pending.push_back(8'h41);
    rx_pending.push_back(CHAR_LF);
    rx_pending.push_back(CHAR_CR);
    rx_pending.push_back(CHAR_LF);
    rx_pending.push_back(CHAR_CR);
    rx_pending.push_back(CHAR_CR);
    rx_pending.push_back(CHAR_LF);
    rx_pending.push_back(CHAR_CR);
    rx_pending.push_back(CHAR_LF);
    for (int i = 0; i < IMAGE_HEADER_BYTES; i++)
      rx_pending.push_back(8'($urandom_range(255)) & ((i >= LEN_FIRST_BYTE &&
                           i < LEN_FIRST_BYTE + 4) ? 8'h00 : 8'hFF));
    push_frame(2, 0);
    rx_pending.push_back(8'h00);
    rx_pending.push_back(8'hFF);
    // leave this frame open across the key change
    push_frame(6, 3);
    wait_drained();

    write_key(32'hFFFF_FFFF);
    push_payload(3);
    run_random(30, 4);
    wait_drained();

    sender_gap_pct <= 72;
    sink_gap_pct   <= 28;
    write_key(32'h0000_0000);
    run_random(30, 4);
    wait_drained();

    sender_gap_pct <= 0;
    sink_gap_pct   <= 0;
    write_key($urandom);
    push_frame(16, 16);
    hold_request = 1'b1;
    run_random(30, 4);
    wait_drained();

    $display("Streamed %0d bytes in %0d frames under %0d key writes and three pacing modes",
             bytes_in, frames_sent, key_writes);
    $display("Checked %0d descrambled bytes, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && payload_expected.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+rtl/core
rtl/core/hbdd_pkg.sv
rtl/core/hbdd_parser.sv
rtl/core/hbdd_out_reg.sv
rtl/core/http_bmp_deframer_descrambler.sv
bench/tb_http_bmp_deframer_descrambler.sv
